### src/bsc_pkg.sv
// bsc_pkg: payload structs, calibration bundle, register indexes and shared helpers
// for the barometric compensation pipeline. No dependencies.
package bsc_pkg;

  localparam int CAL_W     = 48;
  localparam int CFG_IDX_W = 8;
  localparam int DIV_STEPS = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C  = 8'd3;

  // 1/10 reciprocal: (x * RECIP10) >> 35 is exact for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic signed [15:0] temperature_tenths;
    logic signed [15:0] pressure_deca;
    logic               divisor_zero;
  } bsc_out_t;

  // calibration words, already extended to 32 bits
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } bsc_cal_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic [31:0] temp;
    logic        zero;
  } bsc_side_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] sh);
    asr = 32'($signed(v) >>> sh);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction

endpackage

### src/barometric_sensor_compensation.sv
// barometric_sensor_compensation: top level of the 32-bit integer pressure and
// temperature compensation pipeline. Depends on bsc_pkg, bsc_temp, bsc_pscale,
// bsc_div and bsc_post.
//
//   channel  | handshake           | beat
//   ---------+---------------------+----------------------------------------
//   in_      | in_valid/in_stall   | raw temperature + raw pressure
//   out_     | out_valid/out_stall | temperature, pressure, /10 values, flag
//   cfg_     | cfg_valid/cfg_ready | register index + 48-bit calibration word
//
// One beat enters per cycle while in_stall is low; it passes through bsc_temp,
// bsc_pscale, the 32-stage bit-per-stage pressure divider and bsc_post.
// All stages advance together whenever the output register is empty or being
// taken; a held output freezes the whole pipe, so nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and the calibration words.
// Calibration writes are always accepted; indexes beyond three are dropped.
module barometric_sensor_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsc_pkg::bsc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsc_pkg::bsc_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsc_pkg::CAL_W-1:0]      cfg_data
);
  import bsc_pkg::*;

  logic [CAL_W-1:0] tcal_r, pcal_a_r, pcal_b_r, pcal_c_r;
  bsc_cal_t         cal;
  logic             adv;

  logic             t_vld;
  logic [31:0]      t_fine;
  logic [19:0]      t_adc_p;
  logic             p_vld;
  logic [31:0]      p_num, p_den;
  bsc_side_t        p_side;
  logic             d_vld, d_dbl;
  logic [31:0]      d_quo;
  bsc_side_t        d_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r   <= '0;
      pcal_a_r <= '0;
      pcal_b_r <= '0;
      pcal_c_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_CAL: tcal_r   <= cfg_data;
        CFG_PRESS_A:  pcal_a_r <= cfg_data;
        CFG_PRESS_B:  pcal_b_r <= cfg_data;
        CFG_PRESS_C:  pcal_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // T1 and P1 are unsigned words, the rest signed
  always_comb begin
    cal.t1 = {16'd0, tcal_r[15:0]};
    cal.t2 = sx16(tcal_r[31:16]);
    cal.t3 = sx16(tcal_r[47:32]);
    cal.p1 = {16'd0, pcal_a_r[15:0]};
    cal.p2 = sx16(pcal_a_r[31:16]);
    cal.p3 = sx16(pcal_a_r[47:32]);
    cal.p4 = sx16(pcal_b_r[15:0]);
    cal.p5 = sx16(pcal_b_r[31:16]);
    cal.p6 = sx16(pcal_b_r[47:32]);
    cal.p7 = sx16(pcal_c_r[15:0]);
    cal.p8 = sx16(pcal_c_r[31:16]);
    cal.p9 = sx16(pcal_c_r[47:32]);
  end

  // global advance: output register free or being drained
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  bsc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_valid),
    .in_data   (in_data),
    .cal       (cal),
    .out_vld   (t_vld),
    .out_fine  (t_fine),
    .out_adc_p (t_adc_p)
  );

  bsc_pscale u_pscale (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (t_vld),
    .in_fine  (t_fine),
    .in_adc_p (t_adc_p),
    .cal      (cal),
    .out_vld  (p_vld),
    .out_num  (p_num),
    .out_den  (p_den),
    .out_side (p_side)
  );

  bsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p_vld),
    .in_num   (p_num),
    .in_den   (p_den),
    .in_side  (p_side),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_dbl  (d_dbl),
    .out_side (d_side)
  );

  bsc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d_vld),
    .in_quo   (d_quo),
    .in_dbl   (d_dbl),
    .in_side  (d_side),
    .cal      (cal),
    .out_vld  (out_valid),
    .out_data (out_data)
  );
endmodule

### src/bsc_temp.sv
// bsc_temp: three-stage temperature front end, produces the fine temperature.
// Depends on bsc_pkg.
module bsc_temp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  bsc_pkg::bsc_in_t  in_data,
  input  bsc_pkg::bsc_cal_t cal,
  output logic              out_vld,
  output logic [31:0]       out_fine,
  output logic [19:0]       out_adc_p
);
  import bsc_pkg::*;

  logic [2:0]  vld_r;
  logic [31:0] a1_r, dd_r, ta_r, b0_r, fine_r;
  logic [19:0] adc_p1_r, adc_p2_r, adc_p3_r;
  logic [31:0] d1, a1_nxt, dd_nxt, fine_nxt;

  always_comb begin
    a1_nxt   = (32'(in_data.raw_temperature >> 3) - (cal.t1 << 1)) * cal.t2;
    d1       = 32'(in_data.raw_temperature >> 4) - cal.t1;
    dd_nxt   = d1 * d1;
    fine_nxt = ta_r + asr(b0_r, 5'd14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r     <= a1_nxt;
      dd_r     <= dd_nxt;
      adc_p1_r <= in_data.raw_pressure;
      ta_r     <= asr(a1_r, 5'd11);
      b0_r     <= asr(dd_r, 5'd12) * cal.t3;
      adc_p2_r <= adc_p1_r;
      fine_r   <= fine_nxt;
      adc_p3_r <= adc_p2_r;
    end
  end

  assign out_vld   = vld_r[2];
  assign out_fine  = fine_r;
  assign out_adc_p = adc_p3_r;
endmodule

### src/bsc_pscale.sv
// bsc_pscale: seven-stage pressure front end, from fine temperature to the
// dividend and divisor of the pressure division. Depends on bsc_pkg.
module bsc_pscale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [31:0]         in_fine,
  input  logic [19:0]         in_adc_p,
  input  bsc_pkg::bsc_cal_t   cal,
  output logic                out_vld,
  output logic [31:0]         out_num,
  output logic [31:0]         out_den,
  output bsc_pkg::bsc_side_t  out_side
);
  import bsc_pkg::*;

  logic [6:0]  vld_r;
  logic [31:0] temp1_r, temp2_r, temp3_r, temp4_r, temp5_r, temp6_r, temp7_r;
  logic [19:0] adcp1_r, adcp2_r, adcp3_r, adcp4_r, adcp5_r;
  logic [31:0] pa_r, pd_r, dd_r, ap5_r, p2a_r, b1_r, p3m_r, ap5b_r, p2ab_r;
  logic [31:0] b3_r, a2_r, m_r, b3b_r, den6_r, xm_r, den7_r, x0_r;
  logic        zero6_r, zero7_r;
  logic [31:0] temp_nxt, pa_nxt, b3_nxt, a2_nxt, den_nxt, xm_nxt;

  always_comb begin
    temp_nxt = asr(in_fine * 32'd5 + 32'd128, 5'd8);
    pa_nxt   = asr(in_fine, 5'd1) - 32'd64000;
    b3_nxt   = asr(b1_r + (ap5b_r << 1), 5'd2) + (cal.p4 << 16);
    a2_nxt   = asr(asr(p3m_r, 5'd3) + asr(p2ab_r, 5'd1), 5'd18);
    den_nxt  = asr(m_r, 5'd15);
    xm_nxt   = (32'd1048576 - 32'(adcp5_r)) - asr(b3b_r, 5'd12);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      temp1_r <= temp_nxt;
      pa_r    <= pa_nxt;
      pd_r    <= asr(pa_nxt, 5'd2);
      adcp1_r <= in_adc_p;
      // stage 2
      temp2_r <= temp1_r;
      dd_r    <= pd_r * pd_r;
      ap5_r   <= pa_r * cal.p5;
      p2a_r   <= cal.p2 * pa_r;
      adcp2_r <= adcp1_r;
      // stage 3
      temp3_r <= temp2_r;
      b1_r    <= asr(dd_r, 5'd11) * cal.p6;
      p3m_r   <= cal.p3 * asr(dd_r, 5'd13);
      ap5b_r  <= ap5_r;
      p2ab_r  <= p2a_r;
      adcp3_r <= adcp2_r;
      // stage 4
      temp4_r <= temp3_r;
      b3_r    <= b3_nxt;
      a2_r    <= a2_nxt;
      adcp4_r <= adcp3_r;
      // stage 5
      temp5_r <= temp4_r;
      m_r     <= (32'd32768 + a2_r) * cal.p1;
      b3b_r   <= b3_r;
      adcp5_r <= adcp4_r;
      // stage 6
      temp6_r <= temp5_r;
      den6_r  <= den_nxt;
      zero6_r <= (den_nxt == '0);
      xm_r    <= xm_nxt;
      // stage 7
      temp7_r <= temp6_r;
      den7_r  <= den6_r;
      zero7_r <= zero6_r;
      x0_r    <= xm_r * 32'd3125;
    end
  end

  assign out_vld       = vld_r[6];
  assign out_num       = x0_r;
  assign out_den       = den7_r;
  assign out_side.temp = temp7_r;
  assign out_side.zero = zero7_r;
endmodule

### src/bsc_div.sv
// bsc_div: pipelined restoring divider, one quotient bit per stage.
// Depends on bsc_pkg.
module bsc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [31:0]        in_num,
  input  logic [31:0]        in_den,
  input  bsc_pkg::bsc_side_t in_side,
  output logic               out_vld,
  output logic [31:0]        out_quo,
  output logic               out_dbl,
  output bsc_pkg::bsc_side_t out_side
);
  import bsc_pkg::*;

  logic [DIV_STEPS-1:0] vld_r;
  logic [63:0]          acc_r  [DIV_STEPS];
  logic [31:0]          den_r  [DIV_STEPS];
  logic                 dbl_r  [DIV_STEPS];
  bsc_side_t            side_r [DIV_STEPS];
  logic                 dbl0;
  logic [31:0]          num0;

  // small dividends are doubled before the divide, large ones after
  assign dbl0 = in_num[31];
  assign num0 = dbl0 ? in_num : (in_num << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0] acc_in;
    logic [31:0] den_in;
    logic        dbl_in;
    bsc_side_t   side_in;
    logic [32:0] hi, diff;
    logic        ge;
    logic [63:0] acc_nxt;

    if (k == 0) begin : g_first
      assign acc_in  = {32'd0, num0};
      assign den_in  = in_den;
      assign dbl_in  = dbl0;
      assign side_in = in_side;
    end else begin : g_rest
      assign acc_in  = acc_r[k-1];
      assign den_in  = den_r[k-1];
      assign dbl_in  = dbl_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      hi      = acc_in[63:31];
      diff    = hi - {1'b0, den_in};
      ge      = ~diff[32];
      acc_nxt = {(ge ? diff[31:0] : hi[31:0]), acc_in[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r[k]  <= acc_nxt;
        den_r[k]  <= den_in;
        dbl_r[k]  <= dbl_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STEPS-1];
  assign out_quo  = acc_r[DIV_STEPS-1][31:0];
  assign out_dbl  = dbl_r[DIV_STEPS-1];
  assign out_side = side_r[DIV_STEPS-1];
endmodule

### src/bsc_post.sv
// bsc_post: pressure correction after the divide, divide-by-ten of both results
// and the output register. Depends on bsc_pkg.
module bsc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [31:0]        in_quo,
  input  logic               in_dbl,
  input  bsc_pkg::bsc_side_t in_side,
  input  bsc_pkg::bsc_cal_t  cal,
  output logic               out_vld,
  output bsc_pkg::bsc_out_t  out_data
);
  import bsc_pkg::*;

  logic [4:0]  vld_r;
  bsc_side_t   side1_r, side2_r, side3_r, side4_r;
  logic [31:0] x1_r, sq_r, xp8_r, x2_r, pa9_r, xp8b_r, xf_r;
  logic [31:0] xf4_r, mag4_r;
  logic        neg4_r;
  logic [63:0] tprod_r, pprod_r;
  logic [31:0] x_in, q_in, xf_nxt, mag_nxt, tq;
  bsc_out_t    out_r, out_nxt;

  always_comb begin
    x_in    = in_dbl ? (in_quo << 1) : in_quo;
    q_in    = x_in >> 3;
    xf_nxt  = side2_r.zero ? 32'd0 :
              x2_r + asr(asr(pa9_r, 5'd12) + asr(xp8b_r, 5'd13) + cal.p7, 5'd4);
    mag_nxt = side3_r.temp[31] ? (32'd0 - side3_r.temp) : side3_r.temp;
    tq      = neg4_r ? (32'd0 - 32'(tprod_r[63:35])) : 32'(tprod_r[63:35]);
    out_nxt.temperature_centi  = side4_r.temp;
    out_nxt.pressure_pa        = xf4_r;
    out_nxt.temperature_tenths = tq[15:0];
    out_nxt.pressure_deca      = pprod_r[50:35];
    out_nxt.divisor_zero       = side4_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r <= in_side;
      x1_r    <= x_in;
      sq_r    <= q_in * q_in;
      xp8_r   <= (x_in >> 2) * cal.p8;
      side2_r <= side1_r;
      x2_r    <= x1_r;
      pa9_r   <= cal.p9 * (sq_r >> 13);
      xp8b_r  <= xp8_r;
      side3_r <= side2_r;
      xf_r    <= xf_nxt;
      side4_r <= side3_r;
      xf4_r   <= xf_r;
      neg4_r  <= side3_r.temp[31];
      tprod_r <= 64'(mag_nxt) * 64'(RECIP10);
      pprod_r <= 64'(xf_r) * 64'(RECIP10);
      out_r   <= out_nxt;
    end
  end

  assign out_vld  = vld_r[4];
  assign out_data = out_r;
endmodule
